FILE: rtl/core/julian_day_to_calendar_date_macros.svh
// Assertion helpers for the day-number converter.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_MACROS_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_MACROS_SVH

`ifndef SYNTH
// Checked property, masked while reset is asserted.
`define JD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jd2cd assertion failed");
// Checked property, also active during reset.
`define JD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("jd2cd reset assertion failed");
`else
`define JD_ASSERT(lbl, clk, rst_n, prop)
`define JD_ASSERT_RST(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/jd2cd_pkg.sv
`default_nettype none

package jd2cd_pkg;

    localparam int JD_STAGES = 12;

    // stage indexes
    localparam int ST_ALPHA_NUM = 0;
    localparam int ST_ALPHA_EST = 1;
    localparam int ST_ALPHA_REM = 2;
    localparam int ST_ALPHA_FIX = 3;
    localparam int ST_B         = 4;
    localparam int ST_C_NUM     = 5;
    localparam int ST_C_EST     = 6;
    localparam int ST_C_REM     = 7;
    localparam int ST_C_FIX     = 8;
    localparam int ST_DOY       = 9;
    localparam int ST_E         = 10;
    localparam int ST_OUT       = 11;

    typedef logic [JD_STAGES-1:0] t_stage_en;

    // widths
    localparam int DAY_W       = 24;
    localparam int B_W         = 25;
    localparam int ADJ_W       = 11;
    localparam int ALPHA_N_W   = 27;
    localparam int ALPHA_Q_W   = 9;
    localparam int ALPHA_REM_W = 19;
    localparam int ALPHA_RCP_W = 10;
    localparam int ALPHA_PRD_W = ALPHA_N_W + ALPHA_RCP_W;
    localparam int C_N_W       = 29;
    localparam int C_W         = 16;
    localparam int C_REM_W     = 14;
    localparam int C_RCP_W     = 17;
    localparam int C_PRD_W     = C_N_W + C_RCP_W;
    localparam int D_PRD_W     = 27;
    localparam int DOY_W       = 9;
    localparam int E_W         = 4;
    localparam int YEAR_W      = 17;
    localparam int MONTH_W     = 4;
    localparam int DOM_W       = 5;

    // century correction: (4z - 7468865) / 146097, biased by 52 quotients
    localparam int ALPHA_SHIFT = 27;
    localparam int ALPHA_BIAS  = 52;
    localparam logic [ALPHA_N_W-1:0]   ALPHA_OFS   = ALPHA_N_W'(128179);
    localparam logic [ALPHA_N_W-1:0]   ALPHA_DIV   = ALPHA_N_W'(146097);
    localparam logic [ALPHA_RCP_W-1:0] ALPHA_RECIP = ALPHA_RCP_W'(918);
    localparam logic [ADJ_W-1:0]       ADJ_JULIAN  = ADJ_W'(1524);
    localparam logic [ADJ_W-1:0]       ADJ_GREG    = ADJ_W'(1525);

    // year count: (20b - 2442) / 7305
    localparam int C_SHIFT = 29;
    localparam logic [C_N_W-1:0]   C_OFS   = C_N_W'(2442);
    localparam logic [C_N_W-1:0]   C_DIV   = C_N_W'(7305);
    localparam logic [C_RCP_W-1:0] C_RECIP = C_RCP_W'(73493);
    localparam logic [D_PRD_W-1:0] D_MUL   = D_PRD_W'(1461);

    // month and year fix-up
    localparam logic [E_W-1:0]     E_WRAP         = E_W'(14);
    localparam logic [MONTH_W-1:0] MONTH_OFS_LOW  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_OFS_HIGH = MONTH_W'(13);
    localparam logic [MONTH_W-1:0] MONTH_FEB      = MONTH_W'(2);
    localparam logic [YEAR_W-1:0]  YEAR_OFS_LATE  = YEAR_W'(4716);
    localparam logic [YEAR_W-1:0]  YEAR_OFS_EARLY = YEAR_W'(4715);

    localparam logic [DAY_W-1:0] GREG_START_RESET = DAY_W'(2299161);

    // e = floor(10000 x / 306001) for x below 490, capped at 15 above
    function automatic logic [E_W-1:0] doy_to_e(input logic [DOY_W-1:0] x);
        logic [E_W-1:0] e;
        logic [23:0]    lhs;
        e   = '0;
        lhs = 24'(x) * 24'(10000);
        for (int k = 1; k <= 15; k++) begin
            if (lhs >= 24'(k * 306001)) begin
                e = e + E_W'(1);
            end
        end
        return e;
    endfunction

    // floor(306001 e / 10000)
    function automatic logic [DOY_W-1:0] e_start(input logic [E_W-1:0] e);
        logic [DOY_W-1:0] v;
        case (e)
            4'd1:    v = DOY_W'(30);
            4'd2:    v = DOY_W'(61);
            4'd3:    v = DOY_W'(91);
            4'd4:    v = DOY_W'(122);
            4'd5:    v = DOY_W'(153);
            4'd6:    v = DOY_W'(183);
            4'd7:    v = DOY_W'(214);
            4'd8:    v = DOY_W'(244);
            4'd9:    v = DOY_W'(275);
            4'd10:   v = DOY_W'(306);
            4'd11:   v = DOY_W'(336);
            4'd12:   v = DOY_W'(367);
            4'd13:   v = DOY_W'(397);
            4'd14:   v = DOY_W'(428);
            4'd15:   v = DOY_W'(459);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/julian_day_to_calendar_date.sv
// Julian day number to calendar date converter.
// Input channel: i_valid / o_stall with i_julian_day, a whole day number.
// Output channel: o_valid / i_stall with o_year (signed), o_month, o_day.
// A transfer happens on a rising edge where valid is high and stall is low.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data sets the last
// day number converted with Julian calendar rules; o_cfg_ready is always
// high. Write it only while no item is in flight.
// Each item passes stage by stage through the century, year and month
// sections; throughput is one item per cycle while i_stall is low, set by
// the 12-stage pipeline with its two constant reciprocal multiplies.
// Reset clears all stage valid bits and loads cut-over day 2299161.
// When the receiver stalls, the output register holds its result; earlier
// stages keep advancing into empty slots, and o_stall rises only once all
// 12 stages hold an item.
`default_nettype none

`include "julian_day_to_calendar_date_macros.svh"

module julian_day_to_calendar_date
    import jd2cd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [DAY_W-1:0]    i_julian_day,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [YEAR_W-1:0] o_year,
    output logic [MONTH_W-1:0]       o_month,
    output logic [DOM_W-1:0]         o_day,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [DAY_W-1:0]    i_cfg_data
);

    logic [DAY_W-1:0] r_greg_start;
    t_stage_en        r_valid;
    t_stage_en        n_valid;
    t_stage_en        s_rdy;
    t_stage_en        s_vin;
    logic [B_W-1:0]   s_b;
    logic [C_W-1:0]   s_c;
    logic [DOY_W-1:0] s_doy;

    // a stage loads when it is empty or its successor loads
    assign s_rdy[JD_STAGES-1] = !r_valid[JD_STAGES-1] || !i_stall;
    for (genvar k = 0; k < JD_STAGES - 1; k++) begin : g_rdy
        assign s_rdy[k] = !r_valid[k] || s_rdy[k+1];
    end

    assign s_vin   = {r_valid[JD_STAGES-2:0], i_valid};
    assign n_valid = (s_rdy & s_vin) | (~s_rdy & r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_greg_start <= GREG_START_RESET;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_greg_start <= i_cfg_data;
            end
        end
    end

    assign o_stall     = !s_rdy[0];
    assign o_valid     = r_valid[JD_STAGES-1];
    assign o_cfg_ready = 1'b1;

    jd2cd_century u_century (
        .i_clk        (i_clk),
        .i_en         (s_rdy),
        .i_julian_day (i_julian_day),
        .i_greg_start (r_greg_start),
        .o_b          (s_b)
    );

    jd2cd_year u_year (
        .i_clk (i_clk),
        .i_en  (s_rdy),
        .i_b   (s_b),
        .o_c   (s_c),
        .o_doy (s_doy)
    );

    jd2cd_month u_month (
        .i_clk   (i_clk),
        .i_en    (s_rdy),
        .i_doy   (s_doy),
        .i_c     (s_c),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day)
    );

    `JD_ASSERT(a_month_range, i_clk, i_rst_n, o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12))
    `JD_ASSERT(a_day_nonzero, i_clk, i_rst_n, o_valid |-> (o_day != 5'd0))
    `JD_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (&r_valid))
    `JD_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

`default_nettype wire

FILE: rtl/core/jd2cd_century.sv
`default_nettype none

module jd2cd_century
    import jd2cd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_stage_en        i_en,
    input  wire logic [DAY_W-1:0] i_julian_day,
    input  wire logic [DAY_W-1:0] i_greg_start,
    output logic [B_W-1:0]        o_b
);

    logic [DAY_W-1:0]       r_s1_z, r_s2_z, r_s3_z, r_s4_z;
    logic                   r_s1_greg, r_s2_greg, r_s3_greg;
    logic [ALPHA_N_W-1:0]   r_s1_n, r_s2_n;
    logic [ALPHA_Q_W-1:0]   r_s2_q, r_s3_q;
    logic [ALPHA_REM_W-1:0] r_s3_rem;
    logic [ADJ_W-1:0]       r_s4_adj;
    logic [B_W-1:0]         r_s5_b;

    logic [ALPHA_PRD_W-1:0]    s2_prod;
    logic [ALPHA_N_W-1:0]      s3_qd;
    logic [ALPHA_N_W-1:0]      s3_rem;
    logic [ALPHA_Q_W-1:0]      s4_q;
    logic signed [ALPHA_Q_W:0] s4_alpha;
    logic signed [ALPHA_Q_W:0] s4_quarter;
    logic signed [ADJ_W:0]     s4_adj;

    assign s2_prod    = ALPHA_PRD_W'(r_s1_n) * ALPHA_PRD_W'(ALPHA_RECIP);
    assign s3_qd      = ALPHA_N_W'(r_s2_q) * ALPHA_DIV;
    assign s3_rem     = r_s2_n - s3_qd;
    assign s4_q       = r_s3_q + ALPHA_Q_W'(ALPHA_N_W'(r_s3_rem) >= ALPHA_DIV);
    assign s4_alpha   = $signed({1'b0, s4_q}) - $signed((ALPHA_Q_W+1)'(ALPHA_BIAS));
    assign s4_quarter = s4_alpha >>> 2;
    assign s4_adj     = (ADJ_W+1)'(s4_alpha) - (ADJ_W+1)'(s4_quarter)
                      + $signed({1'b0, ADJ_GREG});

    always_ff @(posedge i_clk) begin
        if (i_en[ST_ALPHA_NUM]) begin
            r_s1_z    <= i_julian_day;
            r_s1_greg <= i_julian_day > i_greg_start;
            r_s1_n    <= {1'b0, i_julian_day, 2'b00} + ALPHA_OFS;
        end
        if (i_en[ST_ALPHA_EST]) begin
            r_s2_z    <= r_s1_z;
            r_s2_greg <= r_s1_greg;
            r_s2_n    <= r_s1_n;
            r_s2_q    <= s2_prod[ALPHA_SHIFT+ALPHA_Q_W-1:ALPHA_SHIFT];
        end
        if (i_en[ST_ALPHA_REM]) begin
            r_s3_z    <= r_s2_z;
            r_s3_greg <= r_s2_greg;
            r_s3_q    <= r_s2_q;
            r_s3_rem  <= s3_rem[ALPHA_REM_W-1:0];
        end
        if (i_en[ST_ALPHA_FIX]) begin
            r_s4_z   <= r_s3_z;
            r_s4_adj <= r_s3_greg ? s4_adj[ADJ_W-1:0] : ADJ_JULIAN;
        end
        if (i_en[ST_B]) begin
            r_s5_b <= B_W'(r_s4_z) + B_W'(r_s4_adj);
        end
    end

    assign o_b = r_s5_b;

endmodule

`default_nettype wire

FILE: rtl/core/jd2cd_year.sv
`default_nettype none

module jd2cd_year
    import jd2cd_pkg::*;
(
    input  wire logic           i_clk,
    input  wire t_stage_en      i_en,
    input  wire logic [B_W-1:0] i_b,
    output logic [C_W-1:0]      o_c,
    output logic [DOY_W-1:0]    o_doy
);

    logic [B_W-1:0]     r_s6_b, r_s7_b, r_s8_b, r_s9_b;
    logic [C_N_W-1:0]   r_s6_n, r_s7_n;
    logic [C_W-1:0]     r_s7_q, r_s8_q, r_s9_c, r_s10_c;
    logic [C_REM_W-1:0] r_s8_rem;
    logic [DOY_W-1:0]   r_s10_doy;

    logic [C_PRD_W-1:0] s7_prod;
    logic [C_N_W-1:0]   s8_qd;
    logic [C_N_W-1:0]   s8_rem;
    logic [D_PRD_W-1:0] s10_d_full;
    logic [B_W-1:0]     s10_diff;

    assign s7_prod    = C_PRD_W'(r_s6_n) * C_PRD_W'(C_RECIP);
    assign s8_qd      = C_N_W'(r_s7_q) * C_DIV;
    assign s8_rem     = r_s7_n - s8_qd;
    assign s10_d_full = D_PRD_W'(r_s9_c) * D_MUL;
    assign s10_diff   = r_s9_b - s10_d_full[D_PRD_W-1:2];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_C_NUM]) begin
            r_s6_b <= i_b;
            r_s6_n <= {i_b, 4'b0000} + C_N_W'({i_b, 2'b00}) - C_OFS;
        end
        if (i_en[ST_C_EST]) begin
            r_s7_b <= r_s6_b;
            r_s7_n <= r_s6_n;
            r_s7_q <= s7_prod[C_SHIFT+C_W-1:C_SHIFT];
        end
        if (i_en[ST_C_REM]) begin
            r_s8_b   <= r_s7_b;
            r_s8_q   <= r_s7_q;
            r_s8_rem <= s8_rem[C_REM_W-1:0];
        end
        if (i_en[ST_C_FIX]) begin
            r_s9_b <= r_s8_b;
            r_s9_c <= r_s8_q + C_W'(C_N_W'(r_s8_rem) >= C_DIV);
        end
        if (i_en[ST_DOY]) begin
            r_s10_c   <= r_s9_c;
            r_s10_doy <= s10_diff[DOY_W-1:0];
        end
    end

    assign o_c   = r_s10_c;
    assign o_doy = r_s10_doy;

endmodule

`default_nettype wire

FILE: rtl/core/jd2cd_month.sv
`default_nettype none

module jd2cd_month
    import jd2cd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_stage_en        i_en,
    input  wire logic [DOY_W-1:0] i_doy,
    input  wire logic [C_W-1:0]   i_c,
    output logic signed [YEAR_W-1:0] o_year,
    output logic [MONTH_W-1:0]    o_month,
    output logic [DOM_W-1:0]      o_day
);

    logic [E_W-1:0]     r_s11_e;
    logic [DOY_W-1:0]   r_s11_doy;
    logic [C_W-1:0]     r_s11_c;
    logic signed [YEAR_W-1:0] r_s12_year;
    logic [MONTH_W-1:0] r_s12_month;
    logic [DOM_W-1:0]   r_s12_day;

    logic [MONTH_W-1:0] s12_month;
    logic [YEAR_W-1:0]  s12_year_ofs;
    logic [DOY_W-1:0]   s12_day;

    assign s12_month    = (r_s11_e < E_WRAP) ? MONTH_W'(r_s11_e) - MONTH_OFS_LOW
                                             : MONTH_W'(r_s11_e) - MONTH_OFS_HIGH;
    assign s12_year_ofs = (s12_month > MONTH_FEB) ? YEAR_OFS_LATE : YEAR_OFS_EARLY;
    assign s12_day      = r_s11_doy - e_start(r_s11_e);

    always_ff @(posedge i_clk) begin
        if (i_en[ST_E]) begin
            r_s11_e   <= doy_to_e(i_doy);
            r_s11_doy <= i_doy;
            r_s11_c   <= i_c;
        end
        if (i_en[ST_OUT]) begin
            r_s12_year  <= $signed({1'b0, r_s11_c}) - $signed(s12_year_ofs);
            r_s12_month <= s12_month;
            r_s12_day   <= s12_day[DOM_W-1:0];
        end
    end

    assign o_year  = r_s12_year;
    assign o_month = r_s12_month;
    assign o_day   = r_s12_day;

endmodule

`default_nettype wire
